>>> sv/bmvm_pkg.sv
package bmvm_pkg;

    // Vector store geometry
    localparam int VEC_DEPTH = 1024;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);

    // Field widths
    localparam int DATA_W    = 32;
    localparam int SIZE_W    = 11;
    localparam int POS_W     = 10;
    localparam int PROD_W    = POS_W + SIZE_W;
    localparam int MAX_BLOCK = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE = 2'd0,
        REG_BLOCK_ROW  = 2'd1,
        REG_BLOCK_COL  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_MATRIX = 1'b1
    } cmd_t;

    // One matrix element moving down the MAC pipeline
    typedef struct packed {
        logic              valid;
        logic              eor;
        logic              last;
        logic [VEC_AW-1:0] row_index;
        logic [DATA_W-1:0] value;
    } mac_ctrl_t;

    // One finished row
    typedef struct packed {
        logic [VEC_AW-1:0] row_index;
        logic [DATA_W-1:0] sum;
        logic              last;
    } result_t;

endpackage

>>> sv/bmvm_vec_ram.sv
module bmvm_vec_ram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [bmvm_pkg::VEC_AW-1:0] wr_addr,
    input  logic [bmvm_pkg::DATA_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [bmvm_pkg::VEC_AW-1:0] rd_addr,
    output logic [bmvm_pkg::DATA_W-1:0] rd_data
);

    logic [bmvm_pkg::DATA_W-1:0] mem [bmvm_pkg::VEC_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/bmvm_seq.sv
module bmvm_seq (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmvm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [bmvm_pkg::POS_W-1:0]      vec_index,
    input  logic [bmvm_pkg::DATA_W-1:0]     value,
    input  logic                            out_pop,
    output logic                            ram_wr_en,
    output logic [bmvm_pkg::VEC_AW-1:0]     ram_wr_addr,
    output logic [bmvm_pkg::DATA_W-1:0]     ram_wr_data,
    output logic                            ram_rd_en,
    output logic [bmvm_pkg::VEC_AW-1:0]     ram_rd_addr,
    output bmvm_pkg::mac_ctrl_t             ctrl
);

    logic [bmvm_pkg::SIZE_W-1:0]   size_reg;
    logic [bmvm_pkg::POS_W-1:0]    brow_reg;
    logic [bmvm_pkg::POS_W-1:0]    bcol_reg;
    logic [bmvm_pkg::POS_W-1:0]    col_reg;
    logic [bmvm_pkg::POS_W-1:0]    col_next;
    logic [bmvm_pkg::POS_W-1:0]    row_reg;
    logic [bmvm_pkg::POS_W-1:0]    row_next;
    logic [bmvm_pkg::CREDIT_W-1:0] credit_reg;
    logic [bmvm_pkg::CREDIT_W-1:0] credit_next;
    bmvm_pkg::mac_ctrl_t           ctrl_reg;
    bmvm_pkg::mac_ctrl_t           ctrl_next;

    logic [bmvm_pkg::SIZE_W-1:0]   eff_size;
    logic [bmvm_pkg::SIZE_W-1:0]   col_inc;
    logic [bmvm_pkg::SIZE_W-1:0]   row_inc;
    logic [bmvm_pkg::PROD_W-1:0]   col_addr;
    logic [bmvm_pkg::PROD_W-1:0]   row_addr;
    logic                          in_acc;
    logic                          load_acc;
    logic                          mat_acc;
    logic                          eor;
    logic                          last;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= bmvm_pkg::SIZE_W'(1);
            brow_reg <= '0;
            bcol_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (bmvm_pkg::cfg_reg_t'(cfg_index))
                bmvm_pkg::REG_BLOCK_SIZE: size_reg <= cfg_data;
                bmvm_pkg::REG_BLOCK_ROW:  brow_reg <= cfg_data[bmvm_pkg::POS_W-1:0];
                bmvm_pkg::REG_BLOCK_COL:  bcol_reg <= cfg_data[bmvm_pkg::POS_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Clamp block size into 1..MAX_BLOCK
    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = bmvm_pkg::SIZE_W'(1);
        end
        else if (size_reg > bmvm_pkg::SIZE_W'(bmvm_pkg::MAX_BLOCK))
        begin
            eff_size = bmvm_pkg::SIZE_W'(bmvm_pkg::MAX_BLOCK);
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    // Accept while a result slot is free in the output queue
    assign in_ready = (credit_reg < bmvm_pkg::CREDIT_W'(bmvm_pkg::FIFO_DEPTH));
    assign in_acc   = in_valid && in_ready;
    assign load_acc = in_acc && (bmvm_pkg::cmd_t'(cmd) == bmvm_pkg::CMD_LOAD);
    assign mat_acc  = in_acc && (bmvm_pkg::cmd_t'(cmd) == bmvm_pkg::CMD_MATRIX);

    // Row and column position within the block
    assign col_inc = {1'b0, col_reg} + bmvm_pkg::SIZE_W'(1);
    assign row_inc = {1'b0, row_reg} + bmvm_pkg::SIZE_W'(1);
    assign eor     = !(col_inc < eff_size);
    assign last    = !(row_inc < eff_size);

    // Vector and row addresses, wrapped to the store depth
    assign col_addr = (bmvm_pkg::PROD_W'(bcol_reg) * bmvm_pkg::PROD_W'(eff_size))
                    + bmvm_pkg::PROD_W'(col_reg);
    assign row_addr = (bmvm_pkg::PROD_W'(brow_reg) * bmvm_pkg::PROD_W'(eff_size))
                    + bmvm_pkg::PROD_W'(row_reg);

    // Store ports: loads write, matrix elements read
    assign ram_wr_en   = load_acc;
    assign ram_wr_addr = vec_index[bmvm_pkg::VEC_AW-1:0];
    assign ram_wr_data = value;
    assign ram_rd_en   = mat_acc;
    assign ram_rd_addr = col_addr[bmvm_pkg::VEC_AW-1:0];

    always_comb
    begin
        col_next            = col_reg;
        row_next            = row_reg;
        ctrl_next.valid     = mat_acc;
        ctrl_next.eor       = eor;
        ctrl_next.last      = last;
        ctrl_next.row_index = row_addr[bmvm_pkg::VEC_AW-1:0];
        ctrl_next.value     = value;
        if (mat_acc)
        begin
            if (eor)
            begin
                col_next = '0;
                row_next = last ? '0 : row_inc[bmvm_pkg::POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[bmvm_pkg::POS_W-1:0];
            end
        end
    end

    // Reserve a queue slot for each row end, free it on each output beat
    always_comb
    begin
        case ({mat_acc && eor, out_pop})
            2'b10:   credit_next = credit_reg + bmvm_pkg::CREDIT_W'(1);
            2'b01:   credit_next = credit_reg - bmvm_pkg::CREDIT_W'(1);
            default: credit_next = credit_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            credit_reg <= '0;
            ctrl_reg   <= '0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            credit_reg <= credit_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    assign ctrl = ctrl_reg;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= bmvm_pkg::CREDIT_W'(bmvm_pkg::FIFO_DEPTH))
        else $error("result credit exceeds queue depth");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (mat_acc && !eor) |=> (col_reg == $past(col_reg) + bmvm_pkg::POS_W'(1)))
        else $error("column counter did not advance");

    a_block_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (mat_acc && eor && last) |=> (row_reg == '0 && col_reg == '0))
        else $error("counters not cleared at block end");

endmodule

>>> sv/bmvm_mac.sv
module bmvm_mac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bmvm_pkg::mac_ctrl_t         ctrl,
    input  logic [bmvm_pkg::DATA_W-1:0] rd_data,
    output logic                        push,
    output bmvm_pkg::result_t           push_data
);

    bmvm_pkg::mac_ctrl_t         prod_reg;
    bmvm_pkg::mac_ctrl_t         prod_next;
    logic [bmvm_pkg::DATA_W-1:0] acc_reg;
    logic [bmvm_pkg::DATA_W-1:0] acc_next;
    logic [bmvm_pkg::DATA_W-1:0] acc_sum;

    // Multiply the element by its vector entry, keep the low word
    always_comb
    begin
        prod_next       = ctrl;
        prod_next.value = bmvm_pkg::DATA_W'(ctrl.value * rd_data);
    end

    // Accumulate, and hand the sum on at the end of a row
    assign acc_sum = acc_reg + prod_reg.value;

    always_comb
    begin
        acc_next            = acc_reg;
        push                = 1'b0;
        push_data.row_index = prod_reg.row_index;
        push_data.sum       = acc_sum;
        push_data.last      = prod_reg.last;
        if (prod_reg.valid)
        begin
            if (prod_reg.eor)
            begin
                push     = 1'b1;
                acc_next = '0;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

>>> sv/bmvm_out_fifo.sv
module bmvm_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bmvm_pkg::result_t push_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bmvm_pkg::result_t head
);

    bmvm_pkg::result_t             entry [bmvm_pkg::FIFO_DEPTH];
    logic [bmvm_pkg::FIFO_AW-1:0]  wr_ptr_reg;
    logic [bmvm_pkg::FIFO_AW-1:0]  rd_ptr_reg;
    logic [bmvm_pkg::CREDIT_W-1:0] count_reg;
    logic                          pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = entry[rd_ptr_reg];

    // Hold queued results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + bmvm_pkg::FIFO_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + bmvm_pkg::FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + bmvm_pkg::CREDIT_W'(1);
                2'b01:   count_reg <= count_reg - bmvm_pkg::CREDIT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < bmvm_pkg::CREDIT_W'(bmvm_pkg::FIFO_DEPTH)))
        else $error("result pushed into a full queue");

endmodule

>>> sv/block_matrix_vector_mac_core.sv
// Block matrix-vector multiply-accumulate. Load vector elements first
// (cmd = 0, vec_index, value), then stream the block's matrix elements in
// row-major order (cmd = 1). Each element is multiplied by the stored
// vector entry at block_col*block_size + column (modulo 1024) and summed
// with 32-bit wraparound; after the last column of a row one beat leaves
// with the row index block_row*block_size + row (modulo 1024), the sum and
// last_row. One item is taken every cycle while in_ready is high; out_valid
// rises once the row's final element has passed the vector store read, then
// the multiply, with the accumulate feeding the result queue. An eight-entry
// result queue decouples the output: input is held off only while eight
// results are outstanding. Write the block registers only between blocks,
// with nothing in flight; a load can directly follow or precede a matrix
// element at the same address.
module block_matrix_vector_mac_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmvm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [bmvm_pkg::POS_W-1:0]          vec_index,
    input  logic signed [bmvm_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bmvm_pkg::VEC_AW-1:0]         row_index,
    output logic signed [bmvm_pkg::DATA_W-1:0]  sum,
    output logic                                last_row
);

    logic                        ram_wr_en;
    logic [bmvm_pkg::VEC_AW-1:0] ram_wr_addr;
    logic [bmvm_pkg::DATA_W-1:0] ram_wr_data;
    logic                        ram_rd_en;
    logic [bmvm_pkg::VEC_AW-1:0] ram_rd_addr;
    logic [bmvm_pkg::DATA_W-1:0] ram_rd_data;
    bmvm_pkg::mac_ctrl_t         ctrl;
    logic                        push;
    bmvm_pkg::result_t           push_data;
    bmvm_pkg::result_t           head;
    logic                        out_pop;

    assign out_pop = out_valid && out_ready;

    bmvm_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .vec_index   (vec_index),
        .value       (value),
        .out_pop     (out_pop),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ctrl        (ctrl)
    );

    bmvm_vec_ram u_vec_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bmvm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .rd_data   (ram_rd_data),
        .push      (push),
        .push_data (push_data)
    );

    bmvm_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign row_index = head.row_index;
    assign sum       = head.sum;
    assign last_row  = head.last;

endmodule

>>> sim/block_matrix_vector_mac_core_test.sv
module block_matrix_vector_mac_core_test;

    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE_CYCLES = 12;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [bmvm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [bmvm_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                cmd = 1'b0;
    logic [bmvm_pkg::POS_W-1:0]          vec_index = '0;
    logic signed [bmvm_pkg::DATA_W-1:0]  value = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [bmvm_pkg::VEC_AW-1:0]         row_index;
    logic signed [bmvm_pkg::DATA_W-1:0]  sum;
    logic                                last_row;

    // Mirror of the block state
    logic [bmvm_pkg::DATA_W-1:0] vec_copy [bmvm_pkg::VEC_DEPTH];
    bit                          vec_written [bmvm_pkg::VEC_DEPTH];
    logic [bmvm_pkg::DATA_W-1:0] acc_sum = '0;
    logic [bmvm_pkg::POS_W-1:0]  col_pos = '0;
    logic [bmvm_pkg::POS_W-1:0]  row_pos = '0;
    logic [bmvm_pkg::SIZE_W-1:0] cur_size = 11'd1;
    logic [bmvm_pkg::POS_W-1:0]  cur_row = '0;
    logic [bmvm_pkg::POS_W-1:0]  cur_col = '0;

    bmvm_pkg::result_t expected_rows [$];

    int fail_count = 0;
    int rows_checked = 0;
    int beats_sent = 0;
    int random_beats = 0;
    int settings_used = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int stall_left = 0;

    block_matrix_vector_mac_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .vec_index (vec_index),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row_index (row_index),
        .sum       (sum),
        .last_row  (last_row)
    );

    always #4 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [bmvm_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) != 0)
            return $urandom();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic int unsigned active_size();
        if (cur_size == 0)
            return 1;
        if (cur_size > bmvm_pkg::MAX_BLOCK)
            return bmvm_pkg::MAX_BLOCK;
        return 32'(cur_size);
    endfunction

    // Update the mirrored state for one accepted beat; queue a row when one ends
    task automatic predict_row(input bmvm_pkg::cmd_t c,
                               input logic [bmvm_pkg::POS_W-1:0] idx,
                               input logic [bmvm_pkg::DATA_W-1:0] v);
        int unsigned size;
        int unsigned addr;
        logic [bmvm_pkg::DATA_W-1:0] prod;
        bmvm_pkg::result_t row;
        size = active_size();
        if (c == bmvm_pkg::CMD_LOAD)
        begin
            vec_copy[idx] = v;
            vec_written[idx] = 1'b1;
        end
        else
        begin
            addr = (cur_col * size + col_pos) % bmvm_pkg::VEC_DEPTH;
            prod = v * vec_copy[addr];
            acc_sum = acc_sum + prod;
            if (int'(col_pos) + 1 < int'(size))
            begin
                col_pos = col_pos + bmvm_pkg::POS_W'(1);
            end
            else
            begin
                row.row_index = bmvm_pkg::VEC_AW'((cur_row * size + row_pos)
                                                  % bmvm_pkg::VEC_DEPTH);
                row.sum = acc_sum;
                row.last = (int'(row_pos) + 1 >= int'(size));
                expected_rows.push_back(row);
                acc_sum = '0;
                col_pos = '0;
                row_pos = row.last ? '0 : row_pos + bmvm_pkg::POS_W'(1);
            end
        end
    endtask

    // Present one beat, hold it until accepted, then predict
    task automatic send_item(input bmvm_pkg::cmd_t c,
                             input logic [bmvm_pkg::POS_W-1:0] idx,
                             input logic [bmvm_pkg::DATA_W-1:0] v);
        int gap;
        gap = tx_idle_en ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        vec_index <= idx;
        value     <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_row(c, idx, v);
        beats_sent++;
    endtask

    task automatic send_elem(input logic [bmvm_pkg::DATA_W-1:0] v);
        send_item(bmvm_pkg::CMD_MATRIX,
                  bmvm_pkg::POS_W'($urandom_range(0, bmvm_pkg::VEC_DEPTH - 1)), v);
    endtask

    // Load every store entry that the next elements will read and that holds nothing yet
    task automatic preload_block(input int unsigned n_elem);
        int unsigned size;
        int unsigned c;
        int unsigned addr;
        size = active_size();
        c = col_pos;
        for (int unsigned k = 0; k < n_elem; k++)
        begin
            addr = (cur_col * size + c) % bmvm_pkg::VEC_DEPTH;
            if (!vec_written[addr])
            begin
                send_item(bmvm_pkg::CMD_LOAD, bmvm_pkg::POS_W'(addr), pick_value());
            end
            c = (c + 1 < size) ? c + 1 : 0;
        end
    endtask

    // Drop valid, wait for every expected row, then let the pipeline empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last beat
    task automatic write_reg(input bmvm_pkg::cfg_reg_t r,
                             input logic [bmvm_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (r)
            bmvm_pkg::REG_BLOCK_SIZE: cur_size = d;
            bmvm_pkg::REG_BLOCK_ROW:  cur_row = d[bmvm_pkg::POS_W-1:0];
            bmvm_pkg::REG_BLOCK_COL:  cur_col = d[bmvm_pkg::POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_block(input logic [bmvm_pkg::SIZE_W-1:0] size,
                             input logic [bmvm_pkg::POS_W-1:0] brow,
                             input logic [bmvm_pkg::POS_W-1:0] bcol);
        write_reg(bmvm_pkg::REG_BLOCK_SIZE, size);
        write_reg(bmvm_pkg::REG_BLOCK_ROW, {1'b0, brow});
        write_reg(bmvm_pkg::REG_BLOCK_COL, {1'b0, bcol});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Compare each accepted result beat with the oldest expected row
    task automatic check_row();
        bmvm_pkg::result_t want;
        if (expected_rows.size() == 0)
        begin
            $error("unexpected result: row_index %0d sum %0d last_row %0b",
                   row_index, sum, last_row);
            fail_count++;
        end
        else
        begin
            want = expected_rows.pop_front();
            rows_checked++;
            if (row_index !== want.row_index)
            begin
                $error("row_index: expected %0d, got %0d", want.row_index, row_index);
                fail_count++;
            end
            if (sum !== want.sum)
            begin
                $error("sum: expected %0d, got %0d", $signed(want.sum), sum);
                fail_count++;
            end
            if (last_row !== want.last)
            begin
                $error("last_row: expected %0b, got %0b", want.last, last_row);
                fail_count++;
            end
        end
    endtask

    // Result side: check accepted beats, stall ready at random
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_row();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = rx_idle_en ? gap_len() : 0;
                if (stall_left > 0)
                begin
                    out_ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    out_ready <= 1'b1;
                end
            end
        end
    end

    // Operand extremes on a one-element block; loads directly ahead of reads
    task automatic test_operand_extremes();
        drain_results();
        set_block(11'd0, 10'd0, 10'd0);
        send_item(bmvm_pkg::CMD_LOAD, 10'd0, 32'h8000_0000);
        send_elem(32'h8000_0000);
        send_elem(32'h7FFF_FFFF);
        send_item(bmvm_pkg::CMD_LOAD, 10'd0, 32'h7FFF_FFFF);
        send_elem(32'h7FFF_FFFF);
        send_elem(32'hFFFF_FFFF);
        send_item(bmvm_pkg::CMD_LOAD, 10'd0, 32'hFFFF_FFFF);
        send_item(bmvm_pkg::CMD_MATRIX, 10'h3FF, 32'hFFFF_FFFF);
        send_item(bmvm_pkg::CMD_MATRIX, 10'h000, 32'h0000_0000);
        drain_results();
        set_block(11'd1, 10'd1023, 10'd0);
        send_elem($urandom());
    endtask

    // Loads interleaved with a block, hitting the next address to be read
    task automatic test_load_mid_block();
        int unsigned base;
        drain_results();
        set_block(11'd3, 10'd1023, 10'd511);
        preload_block(9);
        base = (511 * 3) % bmvm_pkg::VEC_DEPTH;
        for (int r = 0; r < 3; r++)
        begin
            send_elem(pick_value());
            send_item(bmvm_pkg::CMD_LOAD, bmvm_pkg::POS_W'(base + 1), pick_value());
            send_elem(pick_value());
            send_elem(pick_value());
        end
    endtask

    // Shrink the block size part-way through a row and a block
    task automatic test_size_change_mid_block();
        drain_results();
        set_block(11'd3, 10'd700, 10'd200);
        preload_block(4);
        repeat (4) send_elem(pick_value());
        drain_results();
        set_block(11'd1, 10'd700, 10'd200);
        preload_block(1);
        send_elem(pick_value());
    endtask

    // Partial rows at the largest size, reached through an oversized write too;
    // a size of one then closes the row and shows the whole sum
    task automatic test_largest_block();
        drain_results();
        set_block(11'd2047, 10'd1023, 10'd1);
        preload_block(20);
        tx_idle_en = 1'b0;
        repeat (20) send_elem($urandom());
        drain_results();
        set_block(11'd1024, 10'd1023, 10'd1);
        preload_block(20);
        repeat (20) send_elem($urandom());
        drain_results();
        tx_idle_en = 1'b1;
        set_block(11'd1, 10'd5, 10'd0);
        preload_block(1);
        send_elem(pick_value());
    endtask

    // Random settings, mostly whole blocks, some cut short or oversized
    task automatic test_random_blocks();
        int sel;
        int unsigned size;
        int unsigned eff;
        int unsigned n_elem;
        int first_beat;
        first_beat = beats_sent;
        while (random_beats < RANDOM_ITEMS)
        begin
            drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 65)
                size = $urandom_range(1, 6);
            else if (sel < 90)
                size = $urandom_range(7, 12);
            else if (sel < 95)
                size = 0;
            else
                size = $urandom_range(bmvm_pkg::MAX_BLOCK + 1, 2047);
            set_block(bmvm_pkg::SIZE_W'(size),
                      bmvm_pkg::POS_W'($urandom_range(0, bmvm_pkg::VEC_DEPTH - 1)),
                      bmvm_pkg::POS_W'($urandom_range(0, bmvm_pkg::VEC_DEPTH - 1)));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            eff = active_size();
            if (eff >= bmvm_pkg::MAX_BLOCK)
                n_elem = $urandom_range(1, 20);
            else if ($urandom_range(0, 4) == 0)
                n_elem = $urandom_range(1, eff * eff);
            else
                n_elem = eff * eff;
            preload_block(n_elem);
            for (int i = 0; i < n_elem; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(bmvm_pkg::CMD_LOAD,
                              bmvm_pkg::POS_W'($urandom_range(0, bmvm_pkg::VEC_DEPTH - 1)),
                              pick_value());
                end
                send_elem(pick_value());
            end
            random_beats = beats_sent - first_beat;
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_operand_extremes();
        test_load_mid_block();
        test_size_change_mid_block();
        test_largest_block();
        test_random_blocks();
        drain_results();
        $display("Sent %0d beats (%0d random) over %0d block settings; checked %0d rows.",
                 beats_sent, random_beats, settings_used, rows_checked);
        $display("Sizes from 0 to 2047 with clamping, operand extremes, loads inside a block,");
        $display("size changes part-way through and full back-pressure from the result side.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(8 * 600000);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
sv/bmvm_pkg.sv
sv/bmvm_vec_ram.sv
sv/bmvm_seq.sv
sv/bmvm_mac.sv
sv/bmvm_out_fifo.sv
sv/block_matrix_vector_mac_core.sv
sim/block_matrix_vector_mac_core_test.sv
